/* sv/rgbc3_pkg.sv */
package rgbc3_pkg;

    localparam int PIX_BITS   = 24;
    localparam int COEF_BITS  = 16;
    localparam int ROW_BITS   = 13;
    localparam int OROW_BITS  = 12;
    localparam int MAX_HEIGHT = 4096;
    localparam int PROD_BITS  = 25;
    localparam int PSUM_BITS  = 27;
    localparam int SUM_BITS   = 29;

    typedef logic [PIX_BITS-1:0]         pix_t;
    typedef pix_t                        win_t [9];
    typedef logic signed [PROD_BITS-1:0] prod_t;
    typedef logic signed [PSUM_BITS-1:0] psum_t;
    typedef logic signed [SUM_BITS-1:0]  sum_t;

    typedef enum logic [2:0] {
        REG_COEF_TOP    = 3'd0,
        REG_COEF_MID    = 3'd1,
        REG_COEF_BOTTOM = 3'd2,
        REG_WIDTH       = 3'd3,
        REG_HEIGHT      = 3'd4
    } cfg_idx_t;

    // per-item control carried alongside the window
    typedef struct packed {
        logic edge_left;
        logic edge_right;
        logic edge_top;
        logic edge_bottom;
        logic row_end;
        logic frame_end;
    } ctl_t;

    function automatic logic signed [COEF_BITS-1:0] coef_at(logic [47:0] r, logic [1:0] k);
        logic signed [COEF_BITS-1:0] v;
        v = $signed(r[k*COEF_BITS +: COEF_BITS]);
        return v;
    endfunction

endpackage

/* sv/rgb_conv3x3_filter_core.sv */
// Path: a result passes the stage-1, product, partial-sum and output registers after the
// transfer of the input that completes its window (one row plus one pixel after its own
// pixel), and an output stall holds it. Throughput: one pixel per clock while the output is
// not stalled; the line store is read and written once per cycle. Reset (aresetn low,
// synchronous): counters, window, valids and config return to reset values; data and line store are left.
module rgb_conv3x3_filter_core
    import rgbc3_pkg::*;
#(
    parameter int MAX_WIDTH      = 1024,
    parameter int COEF_FRAC_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red_in, green_in, blue_in
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // red_out, green_out, blue_out
    output logic        m_tuser,   // row_end
    output logic        m_tlast,   // frame_end
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [47:0] cfg_wdata
);

    localparam int COLW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    // configuration
    logic [47:0] coef_top_reg, coef_mid_reg, coef_bot_reg;
    logic [10:0] width_reg;
    logic [12:0] height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_top_reg <= '0;
            coef_mid_reg <= 48'd16777216;
            coef_bot_reg <= '0;
            width_reg    <= 11'd1024;
            height_reg   <= 13'd768;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_COEF_TOP:    coef_top_reg <= cfg_wdata;
                REG_COEF_MID:    coef_mid_reg <= cfg_wdata;
                REG_COEF_BOTTOM: coef_bot_reg <= cfg_wdata;
                REG_WIDTH:       width_reg    <= cfg_wdata[10:0];
                REG_HEIGHT:      height_reg   <= cfg_wdata[12:0];
                default: ;
            endcase
        end
    end

    // effective size, clamped
    logic [10:0] w_eff;
    logic [12:0] h_eff;
    always_comb begin
        if (width_reg == '0) w_eff = 11'd1;
        else if ({3'b0, width_reg} > 14'(MAX_WIDTH)) w_eff = 11'(MAX_WIDTH);
        else w_eff = width_reg;
        if (height_reg == '0) h_eff = 13'd1;
        else if (height_reg > 13'(MAX_HEIGHT)) h_eff = 13'(MAX_HEIGHT);
        else h_eff = height_reg;
    end

    // whole pipeline moves together; output register frees the input side
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    logic acc;
    assign acc = s_tvalid && adv;

    // stage 0: position counters, decided at transfer
    logic [COLW-1:0]      in_col_reg, out_col_reg;
    logic [ROW_BITS-1:0]  in_row_reg;
    logic [OROW_BITS-1:0] out_row_reg;

    logic col_wrap, emit0, use_pix;
    ctl_t ctl0;
    always_comb begin
        col_wrap = (14'(in_col_reg) + 14'd1) >= 14'(w_eff);
        emit0    = (in_row_reg >= 13'd2) || (in_row_reg == 13'd1 && in_col_reg != '0);
        use_pix  = !s_tuser && (in_row_reg < h_eff);
        ctl0.edge_left   = (out_col_reg == '0);
        ctl0.edge_right  = (14'(out_col_reg) + 14'd1) >= 14'(w_eff);
        ctl0.edge_top    = (out_row_reg == '0);
        ctl0.edge_bottom = (14'(out_row_reg) + 14'd1) >= 14'(h_eff);
        ctl0.row_end     = ctl0.edge_right;
        ctl0.frame_end   = ctl0.edge_right && ctl0.edge_bottom;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else if (acc) begin
            if (emit0 && ctl0.frame_end) begin
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end else begin
                in_col_reg <= col_wrap ? '0 : in_col_reg + 1'b1;
                in_row_reg <= col_wrap ? in_row_reg + 1'b1 : in_row_reg;
                if (emit0) begin
                    if (ctl0.row_end) begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + 1'b1;
                    end else begin
                        out_col_reg <= out_col_reg + 1'b1;
                    end
                end
            end
        end
    end

    // line store: {older row, newer row} per column, read whenever the pipeline advances
    logic [47:0]     line_mem [MAX_WIDTH];
    logic [47:0]     mem_q_reg;
    logic            s1_valid_reg, s1_emit_reg, s1_r1_reg, s1_r2_reg, s1_c0_reg;
    logic [COLW-1:0] s1_col_reg;
    pix_t            s1_pix_reg;
    ctl_t            s1_ctl_reg;
    logic            fwd_reg;
    logic [47:0]     fwd_data_reg;
    logic [47:0]     wr_data;

    always_ff @(posedge aclk) begin
        if (adv) mem_q_reg <= line_mem[in_col_reg];
        if (adv && s1_valid_reg) line_mem[s1_col_reg] <= wr_data;
    end

    // a write landing on the entry just read: bypass it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= acc;
            fwd_reg      <= acc && s1_valid_reg && (s1_col_reg == in_col_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            fwd_data_reg <= wr_data;
            s1_emit_reg  <= emit0;
            s1_r1_reg    <= in_row_reg >= 13'd1;
            s1_r2_reg    <= in_row_reg >= 13'd2;
            s1_c0_reg    <= in_col_reg == '0;
            s1_col_reg   <= in_col_reg;
            s1_pix_reg   <= use_pix ? s_tdata : '0;
            s1_ctl_reg   <= ctl0;
        end
    end

    // stage 1: window update
    win_t win_reg;
    win_t shifted, out_win, masked;
    pix_t older_rd, newer_rd, up_px, mid_px;

    always_comb begin
        {older_rd, newer_rd} = fwd_reg ? fwd_data_reg : mem_q_reg;
        wr_data = {newer_rd, s1_pix_reg};
        up_px   = s1_r2_reg ? older_rd : '0;
        mid_px  = s1_r1_reg ? newer_rd : '0;
        for (int rr = 0; rr < 3; rr++) begin
            shifted[rr*3]   = win_reg[rr*3+1];
            shifted[rr*3+1] = win_reg[rr*3+2];
            out_win[rr*3]   = win_reg[rr*3+1];
            out_win[rr*3+1] = win_reg[rr*3+2];
            out_win[rr*3+2] = '0;
        end
        shifted[2] = up_px;
        shifted[5] = mid_px;
        shifted[8] = s1_pix_reg;
        if (!s1_c0_reg) out_win = shifted;
        for (int i = 0; i < 9; i++) begin
            if ((i % 3 == 0 && s1_ctl_reg.edge_left) || (i % 3 == 2 && s1_ctl_reg.edge_right) ||
                (i / 3 == 0 && s1_ctl_reg.edge_top) || (i / 3 == 2 && s1_ctl_reg.edge_bottom))
                masked[i] = '0;
            else
                masked[i] = out_win[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) win_reg[i] <= '0;
        end else if (adv && s1_valid_reg) begin
            if (s1_emit_reg && s1_ctl_reg.frame_end) begin
                for (int i = 0; i < 9; i++) win_reg[i] <= '0;
            end else begin
                win_reg <= shifted;
            end
        end
    end

    // stage 2: products
    logic  s2_valid_reg, s3_valid_reg;
    logic  s2_re_reg, s2_fe_reg, s3_re_reg, s3_fe_reg;
    prod_t prod_reg [3][9];
    psum_t psum_reg [3][3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_re_reg <= s1_ctl_reg.row_end;
            s2_fe_reg <= s1_ctl_reg.frame_end;
            for (int ch = 0; ch < 3; ch++) begin
                for (int i = 0; i < 9; i++) begin
                    prod_reg[ch][i] <= $signed({1'b0, masked[i][ch*8 +: 8]}) *
                                       coef_at((i / 3 == 0) ? coef_top_reg :
                                               (i / 3 == 1) ? coef_mid_reg : coef_bot_reg,
                                               2'(i % 3));
                end
            end
            // stage 3: row partial sums
            s3_re_reg <= s2_re_reg;
            s3_fe_reg <= s2_fe_reg;
            for (int ch = 0; ch < 3; ch++) begin
                for (int k = 0; k < 3; k++) begin
                    psum_reg[ch][k] <= PSUM_BITS'(prod_reg[ch][k*3]) +
                                       PSUM_BITS'(prod_reg[ch][k*3+1]) +
                                       PSUM_BITS'(prod_reg[ch][k*3+2]);
                end
            end
        end
    end

    // stage 4: final sum, clamp, output register
    sum_t        tot   [3];
    sum_t        shv   [3];
    logic [23:0] rgb_next;
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            tot[ch] = SUM_BITS'(psum_reg[ch][0]) + SUM_BITS'(psum_reg[ch][1]) +
                      SUM_BITS'(psum_reg[ch][2]);
            shv[ch] = tot[ch] >>> COEF_FRAC_BITS;
            if (tot[ch] < 0) rgb_next[ch*8 +: 8] = 8'd0;
            else if (shv[ch] > SUM_BITS'(255)) rgb_next[ch*8 +: 8] = 8'd255;
            else rgb_next[ch*8 +: 8] = shv[ch][7:0];
        end
    end

    logic m_valid_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else if (adv) m_valid_reg <= s3_valid_reg;
    end

    logic [23:0] m_data_reg;
    logic        m_user_reg, m_last_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= rgb_next;
            m_user_reg <= s3_re_reg;
            m_last_reg <= s3_fe_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // checks
    a_last_is_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser) else $error("frame end without row end");

    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        acc && emit0 && ctl0.frame_end |=> in_col_reg == '0 && in_row_reg == '0 &&
        out_col_reg == '0 && out_row_reg == '0) else $error("counters not cleared");

    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s3_valid_reg)) else $error("result without source");

endmodule

/* verif/rgb_conv3x3_checker.sv */
module rgb_conv3x3_checker
    import rgbc3_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [47:0] cfg_wdata,
    output int          fails,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       row_end;
        logic       frame_end;
    } px_res_t;

    logic [47:0] coef_top, coef_mid, coef_bot;
    logic [10:0] width_reg;
    logic [12:0] height_reg;

    pix_t        line_old [1024];
    pix_t        line_new [1024];
    win_t        window;
    int unsigned col_in, row_in, col_out, row_out;
    px_res_t     expected_px [$];

    assign pending = expected_px.size();

    function automatic win_t shift_window(win_t a, pix_t t, pix_t m, pix_t b);
        win_t o;
        o = a;
        for (int rr = 0; rr < 3; rr++) begin
            o[rr*3]   = a[rr*3+1];
            o[rr*3+1] = a[rr*3+2];
        end
        o[2] = t;
        o[5] = m;
        o[8] = b;
        return o;
    endfunction

    function automatic longint coef_val(logic [47:0] r, int k);
        logic signed [15:0] v;
        v = r[k*16 +: 16];
        return longint'(v);
    endfunction

    function automatic logic [7:0] channel_sum(win_t wv, int sh);
        longint sum;
        logic [47:0] rows [3];
        rows[0] = coef_top;
        rows[1] = coef_mid;
        rows[2] = coef_bot;
        sum = 0;
        for (int i = 0; i < 9; i++)
            sum += longint'(wv[i][sh +: 8]) * coef_val(rows[i/3], i % 3);
        if (sum < 0)
            return 8'd0;
        sum = sum >>> 8;
        return (sum > 255) ? 8'd255 : sum[7:0];
    endfunction

    task automatic predict_pixel(input logic op, input pix_t px);
        int unsigned w, h, r, c, ox, oy;
        pix_t        pix, up, mid;
        win_t        wv;
        logic        emit;
        px_res_t     res;
        w = (width_reg == 0) ? 1 : width_reg;
        h = (height_reg == 0) ? 1 : height_reg;
        if (w > 1024) w = 1024;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        r = row_in;
        c = (col_in >= 1024) ? 0 : col_in;
        // pixels past the last row are ignored, drains push zero
        pix  = (op == 1'b0 && r < h) ? px : '0;
        up   = (r >= 2) ? line_old[c] : '0;
        mid  = (r >= 1) ? line_new[c] : '0;
        emit = (r >= 2) || (r == 1 && c >= 1);
        if (c == 0) begin
            wv     = shift_window(window, '0, '0, '0);
            window = shift_window(window, up, mid, pix);
        end else begin
            window = shift_window(window, up, mid, pix);
            wv     = window;
        end
        line_old[c] = line_new[c];
        line_new[c] = pix;
        if (c + 1 >= w) begin
            c = 0;
            r++;
        end else begin
            c++;
        end
        col_in = c;
        row_in = r;
        if (emit) begin
            ox = col_out;
            oy = row_out;
            // zero the neighbours that fall outside the image
            for (int k = 0; k < 3; k++) begin
                if (ox == 0) wv[k*3] = '0;
                if (ox + 1 >= w) wv[k*3+2] = '0;
                if (oy == 0) wv[k] = '0;
                if (oy + 1 >= h) wv[6+k] = '0;
            end
            res.row_end   = (ox + 1 >= w);
            res.frame_end = res.row_end && (oy + 1 >= h);
            res.red       = channel_sum(wv, 0);
            res.green     = channel_sum(wv, 8);
            res.blue      = channel_sum(wv, 16);
            expected_px.push_back(res);
            if (res.frame_end) begin
                foreach (window[i]) window[i] = '0;
                col_in  = 0;
                row_in  = 0;
                col_out = 0;
                row_out = 0;
            end else if (res.row_end) begin
                col_out = 0;
                row_out = (oy + 1) & 12'hFFF;
            end else begin
                col_out = ox + 1;
            end
        end
    endtask

    always @(posedge aclk) begin
        px_res_t e;
        if (!aresetn) begin
            coef_top   = '0;
            coef_mid   = 48'h1000000;
            coef_bot   = '0;
            width_reg  = 11'd1024;
            height_reg = 13'd768;
            foreach (line_old[i]) line_old[i] = '0;
            foreach (line_new[i]) line_new[i] = '0;
            foreach (window[i]) window[i] = '0;
            col_in  = 0;
            row_in  = 0;
            col_out = 0;
            row_out = 0;
            expected_px.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_COEF_TOP:    coef_top   = cfg_wdata;
                    REG_COEF_MID:    coef_mid   = cfg_wdata;
                    REG_COEF_BOTTOM: coef_bot   = cfg_wdata;
                    REG_WIDTH:       width_reg  = cfg_wdata[10:0];
                    REG_HEIGHT:      height_reg = cfg_wdata[12:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_px.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected output transfer data=%h", m_tdata);
                end else begin
                    e = expected_px.pop_front();
                    if (m_tdata != {e.blue, e.green, e.red} || m_tuser != e.row_end ||
                        m_tlast != e.frame_end) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: exp rgb=%h/%h/%h row_end=%b frame_end=%b, got rgb=%h/%h/%h row_end=%b frame_end=%b",
                                     e.red, e.green, e.blue, e.row_end, e.frame_end,
                                     m_tdata[7:0], m_tdata[15:8], m_tdata[23:16],
                                     m_tuser, m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_pixel(s_tuser, s_tdata);
        end
    end

endmodule

/* verif/tb.sv */
module tb;
    import rgbc3_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;  // cycles with no transfer before giving up
    localparam int HOLD_CYCLES = 400;    // long receiver back-pressure

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_addr  = '0;
    logic [47:0] cfg_wdata = '0;

    int fails;
    int pending;

    rgb_conv3x3_filter_core dut (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
        .cfg_we, .cfg_addr, .cfg_wdata
    );

    rgb_conv3x3_checker chk (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
        .cfg_we, .cfg_addr, .cfg_wdata,
        .fails, .pending
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // items waiting to go out on the input channel: {op, blue, green, red}
    logic [24:0] pixel_q [$];
    int  idle_pct   = 21;
    bit  in_took;
    bit  hold_go    = 1'b0;
    bit  hold_seen  = 1'b0;
    int  hold_left  = 0;
    int  items_sent = 0;
    int  quiet      = 0;

    always @(posedge aclk) in_took = s_tvalid && s_tready;

    // input driver: one assignment per signal per falling edge
    always @(negedge aclk) begin
        logic [24:0] it;
        if (aresetn && (!s_tvalid || in_took)) begin
            if (pixel_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                it = pixel_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= it[24];
                s_tdata  <= it[23:0];
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off on request
    always @(negedge aclk) begin
        if (hold_go != hold_seen) begin
            hold_seen = hold_go;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn && ($urandom_range(99) >= idle_pct);
        end
    end

    // watchdog on transfers
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic cfg_write(input cfg_idx_t idx, input logic [47:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // block is idle: last frame end has been seen, let the pipeline settle
    task automatic wait_drained();
        wait (pixel_q.size() == 0 && !s_tvalid);
        wait (pending == 0);
        repeat (8) @(negedge aclk);
    endtask

    task automatic set_coefs(input logic [47:0] t, input logic [47:0] m,
                             input logic [47:0] b);
        cfg_write(REG_COEF_TOP, t);
        cfg_write(REG_COEF_MID, m);
        cfg_write(REG_COEF_BOTTOM, b);
    endtask

    // one whole frame: pixels then width+1 drains; noisy frames swap some ops
    task automatic run_frame(input logic [10:0] wreg, input logic [12:0] hreg,
                             input bit noisy, input bit dark);
        int w, h, n;
        logic        op;
        logic [23:0] px;
        w = (wreg == 0) ? 1 : (wreg > 1024 ? 1024 : wreg);
        h = (hreg == 0) ? 1 : (hreg > MAX_HEIGHT ? MAX_HEIGHT : hreg);
        cfg_write(REG_WIDTH, {37'd0, wreg});
        cfg_write(REG_HEIGHT, {35'd0, hreg});
        n = w * h + w + 1;
        for (int i = 0; i < n; i++) begin
            op = (i >= w * h);
            if (noisy && $urandom_range(5) == 0) op = ~op;
            px = {8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255))};
            if (dark) px = (i % 2) ? 24'hFFFFFF : 24'h000000;
            pixel_q.push_back({op, px[23:16], px[15:8], px[7:0]});
        end
        items_sent += n;
        wait_drained();
    endtask

    function automatic logic [47:0] rand_coefs(input bit tame);
        logic [47:0] v;
        v = 48'({$urandom, $urandom});
        // tame: small weights so sums stay mostly inside 0..255
        if (tame)
            for (int k = 0; k < 3; k++)
                v[k*16 +: 16] = 16'($signed($urandom_range(160)) - 60);
        return v;
    endfunction

    initial begin
        bit tame;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: 3x3 frame, center-weighted filter, alternating black/white pixels
        set_coefs(48'h0040_0040_0040, 48'h0040_0080_0040, 48'h0040_0040_0040);
        run_frame(11'd3, 13'd3, 1'b0, 1'b1);
        // extreme weights: most negative and most positive
        set_coefs(48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF, 48'h0000_7FFF_8000);
        run_frame(11'd2, 13'd2, 1'b1, 1'b0);
        // drain before the image is complete, push after it is
        set_coefs(48'h0, 48'h0100_0100_0100, 48'hFFFF_0000_0001);
        run_frame(11'd1, 13'd1, 1'b1, 1'b0);
        // identity
        set_coefs(48'h0, 48'h0000_0100_0000, 48'h0);
        run_frame(11'd0, 13'd0, 1'b0, 1'b0);

        // random frames, mostly small
        while (items_sent < 1000) begin
            tame = $urandom_range(1);
            set_coefs(rand_coefs(tame), rand_coefs(tame), rand_coefs(tame));
            idle_pct = ($urandom_range(7) == 0) ? 0 : 21;
            if ($urandom_range(9) == 0)
                hold_go = ~hold_go;
            run_frame(11'($urandom_range(1, 9)), 13'($urandom_range(1, 6)),
                      $urandom_range(4) == 0, 1'b0);
        end

        // long receiver hold while the sender keeps offering
        idle_pct = 21;
        set_coefs(rand_coefs(1), rand_coefs(1), rand_coefs(1));
        hold_go = ~hold_go;
        run_frame(11'd64, 13'd6, 1'b0, 1'b0);

        // a last small frame after the long hold
        run_frame(11'd5, 13'd3, 1'b0, 1'b0);

        wait_drained();
        if (fails == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
